// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// expects signals clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property sampled on every edge out of reset
`define OLB_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent on one edge implies consequent on the next
`define OLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/olb_pkg.sv -----
// shared constants for the ordered list buffer: field widths, op and status codes
// no dependencies
`timescale 1ns / 1ps

package olb_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int ELEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_READ      = 3'd1;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd4;
    localparam logic [OP_W-1:0] OP_CONTAINS  = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

// ----- rtl/olb_if.sv -----
// request and response channel interfaces of the ordered list buffer
// depends on olb_pkg
`timescale 1ns / 1ps

interface olb_req_if;
    logic                       valid;
    logic                       ready;
    logic [olb_pkg::OP_W-1:0]   op;
    logic [olb_pkg::POS_W-1:0]  position;
    logic [olb_pkg::ELEM_W-1:0] element;

    modport source (output valid, op, position, element, input ready);
    modport sink (input valid, op, position, element, output ready);
endinterface

interface olb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [olb_pkg::STATUS_W-1:0] status;
    logic [olb_pkg::ELEM_W-1:0]   read_value;
    logic                         found;
    logic [olb_pkg::COUNT_W-1:0]  count;

    modport source (output valid, status, read_value, found, count, input ready);
    modport sink (input valid, status, read_value, found, count, output ready);
endinterface

// ----- rtl/olb_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module olb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ordered_list_buffer.sv -----
// ordered list buffer top level: request sequencer, entry ram, response register
// depends on olb_pkg, olb_if, olb_ram; ready is high only while the sequencer is idle
// append, overwrite, clear, insert at the end and rejected requests go from idle to done;
// read waits in a read wait state; remove shifts later entries down, insert below the end
// shifts up then writes, contains scans; the single ram port steps one entry a cycle
// reset clears the count and the response valid; entries stay undefined until written
`timescale 1ns / 1ps

module ordered_list_buffer #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    olb_req_if.sink     req,
    olb_rsp_if.source   rsp
);

    localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int EW      = ((CW > olb_pkg::POS_W) ? CW : olb_pkg::POS_W) + 1;
    localparam int COUNT_W = olb_pkg::COUNT_W;
    localparam int ELEM_W  = olb_pkg::ELEM_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RD_WAIT  = 7'b0000010,
        S_SHIFT_DN = 7'b0000100,
        S_SHIFT_UP = 7'b0001000,
        S_INS_WR   = 7'b0010000,
        S_SCAN     = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [IW-1:0]                 pos_reg, pos_next;
    logic [ELEM_W-1:0]             elem_reg, elem_next;
    logic [olb_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [ELEM_W-1:0]             res_value_reg, res_value_next;
    logic                          res_found_reg, res_found_next;
    logic                          out_valid_reg, out_valid_next;
    logic [olb_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [ELEM_W-1:0]             out_value_reg, out_value_next;
    logic                          out_found_reg, out_found_next;
    logic [COUNT_W-1:0]            out_count_reg, out_count_next;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [ELEM_W-1:0]             ram_wdata;
    logic [IW-1:0]                 ram_raddr;
    logic [ELEM_W-1:0]             ram_rdata;

    logic [EW-1:0]                 pos_x;
    logic [EW-1:0]                 cnt_x;
    logic [EW-1:0]                 idx_x;
    logic                          elem_zero;
    logic                          list_full;
    logic [IW-1:0]                 req_pos;

    olb_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (1 << IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_x     = EW'(req.position);
    assign cnt_x     = EW'(count_reg);
    assign idx_x     = EW'(idx_reg);
    assign elem_zero = (req.element == '0);
    assign list_full = (cnt_x == EW'(CAPACITY));
    assign req_pos   = IW'(req.position);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.count      = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        elem_next       = elem_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pos_next        = req_pos;
                    elem_next       = req.element;
                    res_status_next = olb_pkg::ST_OK;
                    res_value_next  = '0;
                    res_found_next  = 1'b0;
                    state_next      = S_DONE;
                    case (req.op)
                        olb_pkg::OP_APPEND:
                        begin
                            if (elem_zero)
                            begin
                                res_status_next = olb_pkg::ST_INVALID;
                            end
                            else if (list_full)
                            begin
                                res_status_next = olb_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = IW'(count_reg);
                                ram_wdata  = req.element;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        olb_pkg::OP_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                res_status_next = olb_pkg::ST_INVALID;
                            end
                            else
                            begin
                                ram_raddr  = req_pos;
                                state_next = S_RD_WAIT;
                            end
                        end
                        olb_pkg::OP_OVERWRITE:
                        begin
                            if (elem_zero || (pos_x >= cnt_x))
                            begin
                                res_status_next = olb_pkg::ST_INVALID;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = req_pos;
                                ram_wdata = req.element;
                            end
                        end
                        olb_pkg::OP_REMOVE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                res_status_next = olb_pkg::ST_INVALID;
                            end
                            else if ((pos_x + EW'(1)) < cnt_x)
                            begin
                                idx_next   = req_pos;
                                ram_raddr  = req_pos + IW'(1);
                                state_next = S_SHIFT_DN;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        olb_pkg::OP_INSERT:
                        begin
                            if (elem_zero || (pos_x > cnt_x))
                            begin
                                res_status_next = olb_pkg::ST_INVALID;
                            end
                            else if (list_full)
                            begin
                                res_status_next = olb_pkg::ST_FULL;
                            end
                            else if (pos_x == cnt_x)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = req_pos;
                                ram_wdata  = req.element;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                idx_next   = IW'(count_reg);
                                ram_raddr  = IW'(count_reg) - IW'(1);
                                state_next = S_SHIFT_UP;
                            end
                        end
                        olb_pkg::OP_CONTAINS:
                        begin
                            if (elem_zero)
                            begin
                                res_status_next = olb_pkg::ST_INVALID;
                            end
                            else if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                ram_raddr  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        olb_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status_next = olb_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                res_value_next = ram_rdata;
                state_next     = S_DONE;
            end
            S_SHIFT_DN:
            begin
                // entry idx+1 arrives, lands one place down
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if ((idx_x + EW'(2)) >= cnt_x)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr = idx_reg + IW'(2);
                    idx_next  = idx_reg + IW'(1);
                end
            end
            S_SHIFT_UP:
            begin
                // entry idx-1 arrives, lands one place up
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if ((idx_reg - IW'(1)) == pos_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    ram_raddr = idx_reg - IW'(2);
                    idx_next  = idx_reg - IW'(1);
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = elem_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (ram_rdata == elem_reg)
                begin
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if ((idx_x + EW'(1)) >= cnt_x)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr = idx_reg + IW'(1);
                    idx_next  = idx_reg + IW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_found_next  = res_found_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        elem_reg       <= elem_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

endmodule

// ----- rtl/olb_checker.sv -----
// port-level checker for the ordered list buffer, bound to the top level
// depends on olb_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module olb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [olb_pkg::STATUS_W-1:0] rsp_status,
    input logic [olb_pkg::ELEM_W-1:0]   rsp_read_value,
    input logic                         rsp_found
);

    // response beat holds until taken
    `OLB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // an accepted request keeps the sequencer busy in the following cycle
    `OLB_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready)

    // only defined status codes leave the block
    `OLB_ASSERT(a_status_code, !rsp_valid || (rsp_status == olb_pkg::ST_OK) ||
        (rsp_status == olb_pkg::ST_INVALID) || (rsp_status == olb_pkg::ST_FULL))

    // a hit is a clean contains result with no read value
    `OLB_ASSERT(a_found_ok, !(rsp_valid && rsp_found) ||
        ((rsp_status == olb_pkg::ST_OK) && (rsp_read_value == '0)))

    // a nonzero read value only comes from a successful read
    `OLB_ASSERT(a_value_ok, !(rsp_valid && (rsp_read_value != '0)) ||
        ((rsp_status == olb_pkg::ST_OK) && !rsp_found))

endmodule

bind ordered_list_buffer olb_checker u_olb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value),
    .rsp_found      (rsp.found)
);

// ----- sim/ordered_list_buffer_test.sv -----
// self-checking testbench for the ordered list buffer: directed edge requests, then random traffic
// keeps its own copy of the list to predict every reply; checks replies field by field
// depends on olb_pkg, olb_if and ordered_list_buffer
`timescale 1ns / 1ps

module ordered_list_buffer_test;

    localparam int              OP_W       = olb_pkg::OP_W;
    localparam int              POS_W      = olb_pkg::POS_W;
    localparam int              ELEM_W     = olb_pkg::ELEM_W;
    localparam int              STATUS_W   = olb_pkg::STATUS_W;
    localparam int              COUNT_W    = olb_pkg::COUNT_W;
    localparam int              CAPACITY   = 64;
    localparam int              IDLE_PCT   = 12;
    localparam int              DRAIN_WAIT = 80;
    localparam int              CYCLE_CAP  = 600000;
    localparam logic [OP_W-1:0] OP_UNUSED  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
    } list_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   read_value;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } list_reply_t;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } traffic_mix_t;

    logic clk;
    logic rst_n;

    olb_req_if req_bus ();
    olb_rsp_if rsp_bus ();

    ordered_list_buffer #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    logic [ELEM_W-1:0] list_copy [CAPACITY];
    int unsigned       list_len;
    list_reply_t       pending_replies [$];
    bit                stalls_enabled = 1'b1;
    int                error_count    = 0;
    int                accepted_count = 0;
    int                checked_count  = 0;
    int                full_replies   = 0;
    int                found_replies  = 0;
    int                cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_CAP);
        $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                 pending_replies.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at reply %0d: got %0h want %0h", what, checked_count, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // applies one request to the list copy and returns the reply it must produce
    function automatic list_reply_t apply_list_op(input list_request_t r);
        list_reply_t rep;
        int unsigned pos;
        int unsigned i;
        pos = r.position;
        rep = '0;
        rep.status = olb_pkg::ST_OK;
        case (r.op)
            olb_pkg::OP_APPEND:
            begin
                if (r.element == '0)
                    rep.status = olb_pkg::ST_INVALID;
                else if (list_len >= CAPACITY)
                    rep.status = olb_pkg::ST_FULL;
                else
                begin
                    list_copy[list_len] = r.element;
                    list_len++;
                end
            end
            olb_pkg::OP_READ:
            begin
                if (pos >= list_len)
                    rep.status = olb_pkg::ST_INVALID;
                else
                    rep.read_value = list_copy[pos];
            end
            olb_pkg::OP_OVERWRITE:
            begin
                if (r.element == '0 || pos >= list_len)
                    rep.status = olb_pkg::ST_INVALID;
                else
                    list_copy[pos] = r.element;
            end
            olb_pkg::OP_REMOVE:
            begin
                if (pos >= list_len)
                    rep.status = olb_pkg::ST_INVALID;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_copy[i] = list_copy[i + 1];
                    list_len--;
                end
            end
            olb_pkg::OP_INSERT:
            begin
                if (r.element == '0 || pos > list_len)
                    rep.status = olb_pkg::ST_INVALID;
                else if (list_len >= CAPACITY)
                    rep.status = olb_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > pos; i--)
                        list_copy[i] = list_copy[i - 1];
                    list_copy[pos] = r.element;
                    list_len++;
                end
            end
            olb_pkg::OP_CONTAINS:
            begin
                if (r.element == '0)
                    rep.status = olb_pkg::ST_INVALID;
                else
                begin
                    for (i = 0; i < list_len; i++)
                    begin
                        if (list_copy[i] == r.element)
                            rep.found = 1'b1;
                    end
                end
            end
            olb_pkg::OP_CLEAR:
            begin
                list_len = 0;
            end
            default:
            begin
                rep.status = olb_pkg::ST_INVALID;
            end
        endcase
        rep.count = list_len[COUNT_W-1:0];
        if (rep.status == olb_pkg::ST_FULL)
            full_replies++;
        if (rep.found)
            found_replies++;
        return rep;
    endfunction

    // one request beat; valid stays high into the next call unless it idles first
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] position,
                                input logic [ELEM_W-1:0] element);
        list_request_t r;
        r.op = op;
        r.position = position;
        r.element = element;
        while (stalls_enabled && $urandom_range(99) < IDLE_PCT)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.op       <= op;
        req_bus.position <= position;
        req_bus.element  <= element;
        do
            @(posedge clk);
        while (!req_bus.ready);
        pending_replies.push_back(apply_list_op(r));
        accepted_count++;
    endtask

    // response side: random backpressure, compare each reply beat with the oldest prediction
    initial
    begin
        list_reply_t got;
        list_reply_t want;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                got.status     = rsp_bus.status;
                got.read_value = rsp_bus.read_value;
                got.found      = rsp_bus.found;
                got.count      = rsp_bus.count;
                if (pending_replies.size() == 0)
                    report_mismatch("reply with none pending", 32'(got.count), 32'd0);
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("read_value", got.read_value, want.read_value);
                    check_field("found", 32'(got.found), 32'(want.found));
                    check_field("count", 32'(got.count), 32'(want.count));
                    checked_count++;
                end
            end
            rsp_bus.ready <= !(stalls_enabled && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic test_empty_list_rejects();
        send_request(olb_pkg::OP_READ, 7'd0, 32'h0000_0011);
        send_request(olb_pkg::OP_REMOVE, 7'd0, 32'h0000_0011);
        send_request(olb_pkg::OP_CONTAINS, 7'd0, 32'h0000_0011);
        send_request(olb_pkg::OP_INSERT, 7'd1, 32'h0000_0011);
        send_request(olb_pkg::OP_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_request(olb_pkg::OP_APPEND, 7'd0, 32'h0000_0000);
        send_request(olb_pkg::OP_APPEND, 7'd127, 32'h0000_0001);
        send_request(olb_pkg::OP_OVERWRITE, 7'd0, 32'h0000_0000);
        send_request(olb_pkg::OP_OVERWRITE, 7'd2, 32'h0000_0022);
        send_request(OP_UNUSED, 7'd0, 32'h0000_0001);
        send_request(olb_pkg::OP_READ, 7'd127, 32'h0000_0000);
        send_request(olb_pkg::OP_INSERT, 7'd64, 32'h8000_0000);
    endtask

    task automatic test_edit_at_ends();
        send_request(olb_pkg::OP_INSERT, 7'd2, 32'h0000_0033);
        send_request(olb_pkg::OP_INSERT, 7'd0, 32'h0000_0044);
        send_request(olb_pkg::OP_INSERT, 7'd2, 32'h0000_0055);
        send_request(olb_pkg::OP_OVERWRITE, 7'd4, 32'h7FFF_FFFF);
        send_request(olb_pkg::OP_READ, 7'd0, 32'h0000_0000);
        send_request(olb_pkg::OP_READ, 7'd4, 32'h0000_0000);
        send_request(olb_pkg::OP_REMOVE, 7'd0, 32'h0000_0000);
        send_request(olb_pkg::OP_REMOVE, 7'd3, 32'h0000_0000);
        send_request(olb_pkg::OP_CONTAINS, 7'd0, 32'hFFFF_FFFF);
        send_request(olb_pkg::OP_CONTAINS, 7'd0, 32'h0000_0000);
        send_request(olb_pkg::OP_REMOVE, 7'd1, 32'h0000_0000);
        send_request(olb_pkg::OP_CONTAINS, 7'd0, 32'h0000_0055);
        send_request(olb_pkg::OP_CLEAR, 7'd127, 32'hFFFF_FFFF);
        send_request(olb_pkg::OP_READ, 7'd0, 32'h0000_0000);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input traffic_mix_t mix);
        int roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_GROW:
            begin
                if (roll < 35) return olb_pkg::OP_APPEND;
                if (roll < 65) return olb_pkg::OP_INSERT;
                if (roll < 75) return olb_pkg::OP_READ;
                if (roll < 83) return olb_pkg::OP_OVERWRITE;
                if (roll < 88) return olb_pkg::OP_REMOVE;
                if (roll < 98) return olb_pkg::OP_CONTAINS;
            end
            MIX_SHRINK:
            begin
                if (roll < 10) return olb_pkg::OP_APPEND;
                if (roll < 15) return olb_pkg::OP_INSERT;
                if (roll < 25) return olb_pkg::OP_READ;
                if (roll < 33) return olb_pkg::OP_OVERWRITE;
                if (roll < 83) return olb_pkg::OP_REMOVE;
                if (roll < 98) return olb_pkg::OP_CONTAINS;
            end
            default:
            begin
                if (roll < 20) return olb_pkg::OP_APPEND;
                if (roll < 40) return olb_pkg::OP_INSERT;
                if (roll < 55) return olb_pkg::OP_READ;
                if (roll < 65) return olb_pkg::OP_OVERWRITE;
                if (roll < 85) return olb_pkg::OP_REMOVE;
                if (roll < 98) return olb_pkg::OP_CONTAINS;
            end
        endcase
        return (roll < 99) ? olb_pkg::OP_CLEAR : OP_UNUSED;
    endfunction

    task automatic run_traffic(input traffic_mix_t mix, input int beats);
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
        int                roll;
        repeat (beats)
        begin
            op = pick_op(mix);
            if ($urandom_range(99) < 15)
                position = POS_W'($urandom_range(127));
            else if (op == olb_pkg::OP_INSERT)
                position = POS_W'($urandom_range(list_len));
            else
                position = (list_len == 0) ? '0 : POS_W'($urandom_range(list_len - 1));
            roll = $urandom_range(99);
            if (roll < 5)
                element = '0;
            else if (roll < 50 && list_len != 0
                     && (op == olb_pkg::OP_CONTAINS || op == olb_pkg::OP_OVERWRITE
                         || op == olb_pkg::OP_INSERT))
                element = list_copy[$urandom_range(list_len - 1)];
            else if (roll < 75)
                element = $urandom_range(1, 24);
            else
                element = $urandom;
            send_request(op, position, element);
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(MIX_GROW, 200);
        run_traffic(MIX_SHRINK, 150);
        stalls_enabled = 1'b0;
        run_traffic(MIX_BALANCED, 250);
        stalls_enabled = 1'b1;
        run_traffic(MIX_GROW, 200);
        run_traffic(MIX_SHRINK, 100);
        run_traffic(MIX_BALANCED, 200);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.op       <= olb_pkg::OP_APPEND;
        req_bus.position <= '0;
        req_bus.element  <= '0;
        list_len = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list_rejects();
        test_edit_at_ends();
        test_random_traffic();

        req_bus.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests sent, %0d replies checked over all seven ops and an unused op",
                 accepted_count, checked_count);
        $display("%0d full rejections, %0d successful lookups, %0d cycles", full_replies,
                 found_replies, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
